[rtl/cgpm_pkg.sv]
// types and constants shared by the c-scan gate pixel mapper
// no dependencies
`timescale 1ns / 1ps

package cgpm_pkg;

  localparam int unsigned AMP_W      = 8;
  localparam int unsigned TH_W       = 24;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned Q_W        = PIX_W;
  localparam int unsigned NUM_W      = TH_W + Q_W;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = TH_W;
  localparam int unsigned DIV_STEPS  = Q_W;

  localparam logic [PIX_W-1:0]  PIX_MAX    = 8'hFF;
  localparam logic [PIX_W-1:0]  PIX_MIN    = 8'h00;
  localparam logic [TH_W-1:0]   STOP_RST   = 24'd100000;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd256;

  typedef enum logic [MODE_W-1:0] {
    MODE_AMP  = 2'd0,
    MODE_POS  = 2'd1,
    MODE_DIST = 2'd2
  } map_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_HFIRST = 3'd1,
    REG_HSEC   = 3'd2,
    REG_START  = 3'd3,
    REG_STOP   = 3'd4,
    REG_GAIN   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [MODE_W-1:0] map_mode;
    logic [AMP_W-1:0]  gate_height_first;
    logic [AMP_W-1:0]  gate_height_second;
    logic [TH_W-1:0]   thickness_start;
    logic [TH_W-1:0]   thickness_stop;
    logic [GAIN_W-1:0] gain_scale;
  } cfg_t;

  // one item inside the divider pipe
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [TH_W-1:0]  span;
    logic [Q_W-1:0]   quo;
    logic             forced;
    logic [PIX_W-1:0] fixed_pix;
    logic             last;
  } div_t;

endpackage

[rtl/cscan_gate_pixel_mapper.sv]
// top level of the c-scan gate pixel mapper: config registers, front end, divider pipe
// depends on cgpm_pkg, cgpm_front, cgpm_div_stage
`timescale 1ns / 1ps

// Maps one beam's gate peaks to an 8-bit C-scan pixel in amplitude, position or
// distance mode. One beat is taken every cycle while the pipe is not full and stalled;
// a beat passes three front-end stages and eight divider stages (one quotient bit per
// stage), and every stage holds its beat while the output is stalled, so empty
// stages still fill. Registers may be written only while no beat is in flight.

module cscan_gate_pixel_mapper #(
  parameter int unsigned DEPTH_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cgpm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cgpm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // depth_first, amp_first, depth_second, amp_second
  input  logic [((2*DEPTH_BITS+2*cgpm_pkg::AMP_W+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pixel
  output logic [cgpm_pkg::PIX_W-1:0]          m_axis_tdata,
  output logic                                m_axis_tlast
);
  import cgpm_pkg::*;

  localparam int unsigned NSTG = DIV_STEPS;

  cfg_t                  cfg_q;
  logic [NSTG:0]         div_v;
  logic [NSTG:0]         div_rdy;
  div_t                  div_d [NSTG+1];
  logic                  front_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_mode           <= MODE_POS;
      cfg_q.gate_height_first  <= '0;
      cfg_q.gate_height_second <= '0;
      cfg_q.thickness_start    <= '0;
      cfg_q.thickness_stop     <= STOP_RST;
      cfg_q.gain_scale         <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODE:   cfg_q.map_mode           <= cfg_data_i[MODE_W-1:0];
        REG_HFIRST: cfg_q.gate_height_first  <= cfg_data_i[AMP_W-1:0];
        REG_HSEC:   cfg_q.gate_height_second <= cfg_data_i[AMP_W-1:0];
        REG_START:  cfg_q.thickness_start    <= cfg_data_i[TH_W-1:0];
        REG_STOP:   cfg_q.thickness_stop     <= cfg_data_i[TH_W-1:0];
        REG_GAIN:   cfg_q.gain_scale         <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  cgpm_front #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (s_axis_tvalid),
    .ready_o       (front_rdy),
    .depth_first_i (s_axis_tdata[DEPTH_BITS-1:0]),
    .amp_first_i   (s_axis_tdata[DEPTH_BITS +: AMP_W]),
    .depth_second_i(s_axis_tdata[DEPTH_BITS+AMP_W +: DEPTH_BITS]),
    .amp_second_i  (s_axis_tdata[2*DEPTH_BITS+AMP_W +: AMP_W]),
    .last_i        (s_axis_tlast),
    .valid_o       (div_v[0]),
    .ready_i       (div_rdy[0]),
    .data_o        (div_d[0])
  );

  assign s_axis_tready = front_rdy;

  for (genvar k = 0; k < NSTG; k++) begin : g_div
    cgpm_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(div_v[k]),
      .ready_o(div_rdy[k]),
      .data_i (div_d[k]),
      .valid_o(div_v[k+1]),
      .ready_i(div_rdy[k+1]),
      .data_o (div_d[k+1])
    );
  end

  assign div_rdy[NSTG]  = m_axis_tready;
  assign m_axis_tvalid  = div_v[NSTG];
  assign m_axis_tlast   = div_d[NSTG].last;
  assign m_axis_tdata   = div_d[NSTG].forced ? div_d[NSTG].fixed_pix : div_d[NSTG].quo;

  // divider only ever sees a non-zero span on beats that are not forced
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v[0] && !div_d[0].forced |-> div_d[0].span != '0)
    else $error("divider entered with zero span");

  // quotient fits in eight bits
  a_num_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v[0] && !div_d[0].forced |->
      div_d[0].num < {div_d[0].span, {Q_W{1'b0}}})
    else $error("dividend out of range");

  // the divider pipe only backs up when every stage is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !div_rdy[0] |-> &div_v[NSTG:1])
    else $error("divider stalled with an empty stage");

endmodule

[rtl/cgpm_front.sv]
// front end: amplitude gain scaling, gate checks, depth select, bound compares and 255x scaling
// three register stages, depends on cgpm_pkg
`timescale 1ns / 1ps

module cgpm_front #(
  parameter int unsigned DEPTH_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cgpm_pkg::cfg_t                cfg_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [DEPTH_BITS-1:0]         depth_first_i,
  input  logic [cgpm_pkg::AMP_W-1:0]    amp_first_i,
  input  logic [DEPTH_BITS-1:0]         depth_second_i,
  input  logic [cgpm_pkg::AMP_W-1:0]    amp_second_i,
  input  logic                          last_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output cgpm_pkg::div_t                data_o
);
  import cgpm_pkg::*;

  localparam int unsigned CMP_W  = (DEPTH_BITS > TH_W) ? DEPTH_BITS : TH_W;
  localparam int unsigned PROD_W = AMP_W + GAIN_W;
  localparam int unsigned AMPS_W = PROD_W - 8;

  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;

  // stage 1 payload
  logic                  amp_mode_q, amp_mode_d;
  logic                  gate_fail_q, gate_fail_d;
  logic [PIX_W-1:0]      fail_pix_q, fail_pix_d;
  logic [DEPTH_BITS-1:0] dsel_q, dsel_d;
  logic [AMPS_W-1:0]     amp_scl_q, amp_scl_d;
  logic                  last1_q;
  logic [PROD_W-1:0]     prod;
  logic                  dist_mode;

  // stage 2 and 3 payload
  div_t                  f2_q, f2_d;
  div_t                  f3_q, f3_d;
  logic [CMP_W-1:0]      dsel_ext, start_ext, stop_ext, n_ext;
  logic [TH_W-1:0]       span;
  logic [PIX_W-1:0]      amp_pix;

  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;
  assign valid_o = v3_q;
  assign data_o  = f3_q;

  always_comb begin
    dist_mode   = (cfg_i.map_mode != MODE_AMP) && (cfg_i.map_mode != MODE_POS);
    amp_mode_d  = (cfg_i.map_mode == MODE_AMP);
    prod        = PROD_W'(amp_first_i) * PROD_W'(cfg_i.gain_scale);
    amp_scl_d   = prod[PROD_W-1:8];
    gate_fail_d = (amp_first_i < cfg_i.gate_height_first) ||
                  (dist_mode && (amp_second_i < cfg_i.gate_height_second));
    fail_pix_d  = dist_mode ? PIX_MAX : PIX_MIN;
    if (!dist_mode) begin
      dsel_d = depth_first_i;
    end else if (depth_second_i >= depth_first_i) begin
      dsel_d = depth_second_i - depth_first_i;
    end else begin
      dsel_d = depth_first_i - depth_second_i;
    end
  end

  always_comb begin
    dsel_ext  = CMP_W'(dsel_q);
    start_ext = CMP_W'(cfg_i.thickness_start);
    stop_ext  = CMP_W'(cfg_i.thickness_stop);
    n_ext     = dsel_ext - start_ext;
    span      = cfg_i.thickness_stop - cfg_i.thickness_start;
    amp_pix   = (amp_scl_q > AMPS_W'(PIX_MAX)) ? PIX_MAX : amp_scl_q[PIX_W-1:0];
    f2_d           = '0;
    f2_d.num       = NUM_W'(n_ext[TH_W-1:0]);
    f2_d.span      = span;
    f2_d.last      = last1_q;
    f2_d.forced    = 1'b1;
    if (amp_mode_q) begin
      f2_d.fixed_pix = amp_pix;
    end else if (gate_fail_q) begin
      f2_d.fixed_pix = fail_pix_q;
    end else if (dsel_ext < start_ext) begin
      f2_d.fixed_pix = PIX_MIN;
    end else if (dsel_ext > stop_ext) begin
      f2_d.fixed_pix = PIX_MAX;
    end else if (span == '0) begin
      f2_d.fixed_pix = PIX_MIN;
    end else begin
      f2_d.forced    = 1'b0;
      f2_d.fixed_pix = PIX_MIN;
    end
  end

  // 255 * n as (n << 8) - n
  always_comb begin
    f3_d     = f2_q;
    f3_d.num = {f2_q.num[TH_W-1:0], {Q_W{1'b0}}} - f2_q.num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && valid_i) begin
      amp_mode_q  <= amp_mode_d;
      gate_fail_q <= gate_fail_d;
      fail_pix_q  <= fail_pix_d;
      dsel_q      <= dsel_d;
      amp_scl_q   <= amp_scl_d;
      last1_q     <= last_i;
    end
    if (r2 && v1_q) f2_q <= f2_d;
    if (r3 && v2_q) f3_q <= f3_d;
  end

endmodule

[rtl/cgpm_div_stage.sv]
// one restoring division step: yields one quotient bit, msb first
// depends on cgpm_pkg
`timescale 1ns / 1ps

module cgpm_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cgpm_pkg::div_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cgpm_pkg::div_t data_o
);
  import cgpm_pkg::*;

  logic             valid_q;
  div_t             data_q, data_d;
  logic [NUM_W-1:0] trial, rem;
  logic             ge;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    trial       = NUM_W'({data_i.span, {(Q_W-1){1'b0}}});
    ge          = data_i.num >= trial;
    rem         = ge ? (data_i.num - trial) : data_i.num;
    data_d      = data_i;
    data_d.num  = {rem[NUM_W-2:0], 1'b0};
    data_d.quo  = {data_i.quo[Q_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

[bench/tb.sv]
// self-checking bench for cscan_gate_pixel_mapper: stream driver, monitor and pixel predictor
// depends on cgpm_pkg and the cscan_gate_pixel_mapper rtl
`timescale 1ns / 1ps

module tb;
  import cgpm_pkg::*;

  localparam int unsigned DEPTH_W   = 24;
  localparam int unsigned PHASES    = 7;
  localparam int unsigned PHASE_LEN = 200;
  localparam int unsigned HOLD_LEN  = 200;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_first;
    logic [AMP_W-1:0]   amp_first;
    logic [DEPTH_W-1:0] depth_second;
    logic [AMP_W-1:0]   amp_second;
    logic               last_beam;
  } beam_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_out;
  } pixel_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIX_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;

  cscan_gate_pixel_mapper #(
    .DEPTH_BITS(DEPTH_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cfg_t   reg_shadow;
  beam_t  beam_q[$];
  pixel_t expected_pixels[$];
  bit     calm = 1'b0;

  beam_t  cur_beam;
  int     tx_idle = 0;
  int     rx_idle = 0;
  int     rx_hold = 0;
  bit     hold_done = 1'b0;
  int     rx_count = 0;
  int     mismatch_count = 0;
  pixel_t got_pixel;
  pixel_t want_pixel;

  function automatic logic [PIX_W-1:0] scale_depth(logic [TH_W-1:0] d);
    logic [TH_W-1:0] span;
    logic [31:0]     q;
    if (d < reg_shadow.thickness_start) return PIX_MIN;
    if (d > reg_shadow.thickness_stop) return PIX_MAX;
    span = reg_shadow.thickness_stop - reg_shadow.thickness_start;
    if (span == '0) return PIX_MIN;
    q = (32'd255 * (d - reg_shadow.thickness_start)) / span;
    return (q > 32'd255) ? PIX_MAX : q[PIX_W-1:0];
  endfunction

  function automatic pixel_t predict_pixel(beam_t b);
    pixel_t          r;
    logic [23:0]     prod;
    logic [TH_W-1:0] diff;
    r.last_out = b.last_beam;
    if (reg_shadow.map_mode == MODE_AMP) begin
      prod = b.amp_first * reg_shadow.gain_scale;
      r.pixel = (prod[23:8] > 16'd255) ? PIX_MAX : prod[15:8];
    end else if (reg_shadow.map_mode == MODE_POS) begin
      if (b.amp_first < reg_shadow.gate_height_first) r.pixel = PIX_MIN;
      else r.pixel = scale_depth(b.depth_first);
    end else begin
      // distance, also taken for the unused mode code
      if (b.amp_first >= reg_shadow.gate_height_first &&
          b.amp_second >= reg_shadow.gate_height_second) begin
        diff = (b.depth_second >= b.depth_first) ? b.depth_second - b.depth_first
                                                 : b.depth_first - b.depth_second;
        r.pixel = scale_depth(diff);
      end else begin
        r.pixel = PIX_MAX;
      end
    end
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_pixels.push_back(predict_pixel(cur_beam));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_idle > 0) begin
          tx_idle--;
          s_axis_tvalid <= 1'b0;
        end else if (beam_q.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
          tx_idle = $urandom_range(0, 15);
          s_axis_tvalid <= 1'b0;
        end else if (beam_q.size() > 0) begin
          cur_beam = beam_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_beam.amp_second, cur_beam.depth_second,
                            cur_beam.amp_first, cur_beam.depth_first};
          s_axis_tlast  <= cur_beam.last_beam;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_pixel = {m_axis_tdata, m_axis_tlast};
        rx_count++;
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected beat: pixel %0d last %0b", got_pixel.pixel, got_pixel.last_out);
        end else begin
          want_pixel = expected_pixels.pop_front();
          if (got_pixel.pixel !== want_pixel.pixel ||
              got_pixel.last_out !== want_pixel.last_out) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch at beat %0d: pixel exp %0d got %0d, last exp %0b got %0b",
                       rx_count, want_pixel.pixel, got_pixel.pixel,
                       want_pixel.last_out, got_pixel.last_out);
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && rx_count >= 300 && beam_q.size() > 40) begin
        // long back-pressure so the pipe fills and stalls its input
        hold_done = 1'b1;
        rx_hold = HOLD_LEN - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_idle > 0) begin
        rx_idle--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rx_idle = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic cfg_t make_cfg(logic [MODE_W-1:0] mode, logic [AMP_W-1:0] h1,
                                    logic [AMP_W-1:0] h2, logic [TH_W-1:0] start,
                                    logic [TH_W-1:0] stop, logic [GAIN_W-1:0] gain);
    cfg_t c;
    c.map_mode           = mode;
    c.gate_height_first  = h1;
    c.gate_height_second = h2;
    c.thickness_start    = start;
    c.thickness_stop     = stop;
    c.gain_scale         = gain;
    return c;
  endfunction

  function automatic logic [AMP_W-1:0] rand_height();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return AMP_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    logic [TH_W-1:0]   a;
    logic [TH_W-1:0]   b;
    logic [GAIN_W-1:0] g;
    a = TH_W'($urandom());
    b = TH_W'($urandom());
    case ($urandom_range(0, 5))
      0: begin a = '0; b = '1; end
      1: begin a = TH_W'($urandom_range(0, 999)); b = TH_W'(a + $urandom_range(1, 2000)); end
      2: b = a;
      3: if (a < b) begin a = a ^ b; b = a ^ b; a = a ^ b; end else if (a == b) a = a + 1'b1;
      default: if (a > b) begin a = a ^ b; b = a ^ b; a = a ^ b; end
    endcase
    case ($urandom_range(0, 4))
      0:       g = 16'h0000;
      1:       g = 16'hFFFF;
      2:       g = GAIN_RST;
      default: g = GAIN_W'($urandom());
    endcase
    return make_cfg(MODE_W'($urandom_range(0, 3)), rand_height(), rand_height(), a, b, g);
  endfunction

  function automatic logic [TH_W-1:0] rand_depth(cfg_t c);
    logic [TH_W-1:0] d;
    d = TH_W'($urandom());
    case ($urandom_range(0, 7))
      0, 1: ;
      2: d = TH_W'(c.thickness_start + $urandom_range(0, 2) - 1);
      3: d = TH_W'(c.thickness_stop + $urandom_range(0, 2) - 1);
      default:
        if (c.thickness_start <= c.thickness_stop)
          d = TH_W'($urandom_range(c.thickness_stop, c.thickness_start));
    endcase
    return d;
  endfunction

  function automatic logic [AMP_W-1:0] rand_amp(logic [AMP_W-1:0] h);
    case ($urandom_range(0, 5))
      0:       return h - 8'd1;
      1:       return h;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return AMP_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void queue_beam(logic [TH_W-1:0] d1, logic [AMP_W-1:0] a1,
                                     logic [TH_W-1:0] d2, logic [AMP_W-1:0] a2,
                                     logic last);
    beam_t b;
    b.depth_first  = d1;
    b.amp_first    = a1;
    b.depth_second = d2;
    b.amp_second   = a2;
    b.last_beam    = last;
    beam_q.push_back(b);
  endfunction

  function automatic void queue_random_beam(cfg_t c);
    logic [TH_W-1:0] d1;
    logic [TH_W-1:0] d2;
    logic [TH_W-1:0] diff;
    d1 = rand_depth(c);
    d2 = TH_W'($urandom());
    if (c.map_mode[1] && $urandom_range(0, 3) != 0) begin
      diff = rand_depth(c);
      d1 = TH_W'($urandom_range(24'hFFFFFF - diff, 0));
      d2 = d1 + diff;
      if ($urandom_range(0, 1)) begin d1 = d1 ^ d2; d2 = d1 ^ d2; d1 = d1 ^ d2; end
    end
    queue_beam(d1, rand_amp(c.gate_height_first), d2, rand_amp(c.gate_height_second),
               $urandom_range(0, 7) == 0);
  endfunction

  // sampled away from the rising edge so driver and monitor updates have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (beam_q.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic apply_cfg(cfg_t c);
    wait_drained();
    write_reg(REG_MODE,   CFG_DATA_W'(c.map_mode));
    write_reg(REG_HFIRST, CFG_DATA_W'(c.gate_height_first));
    write_reg(REG_HSEC,   CFG_DATA_W'(c.gate_height_second));
    write_reg(REG_START,  c.thickness_start);
    write_reg(REG_STOP,   c.thickness_stop);
    write_reg(REG_GAIN,   CFG_DATA_W'(c.gain_scale));
    reg_shadow = c;
  endtask

  initial begin
    cfg_t c;
    reg_shadow = make_cfg(MODE_POS, 8'h00, 8'h00, '0, STOP_RST, GAIN_RST);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values, position mode across the span
    queue_beam(24'd0,      8'h00, 24'hFFFFFF, 8'hFF, 1'b0);
    queue_beam(24'd50000,  8'hFF, 24'd0,      8'h00, 1'b1);
    queue_beam(24'd100000, 8'h10, 24'd5,      8'h20, 1'b0);
    queue_beam(24'd100001, 8'h80, 24'd7,      8'h01, 1'b0);
    queue_beam(24'hFFFFFF, 8'h01, 24'hFFFFFF, 8'hFF, 1'b1);

    // amplitude mode, largest gain saturates
    apply_cfg(make_cfg(MODE_AMP, 8'h00, 8'h00, '0, STOP_RST, 16'hFFFF));
    queue_beam(24'hFFFFFF, 8'h00, 24'h000000, 8'h00, 1'b0);
    queue_beam(24'h000000, 8'h01, 24'hFFFFFF, 8'hFF, 1'b0);
    queue_beam(24'h123456, 8'hFF, 24'h654321, 8'h00, 1'b1);

    // zero span and gate threshold in position mode
    apply_cfg(make_cfg(MODE_POS, 8'h80, 8'h00, 24'd5000, 24'd5000, GAIN_RST));
    queue_beam(24'd5000, 8'h80, 24'd0, 8'h00, 1'b0);
    queue_beam(24'd4999, 8'hFF, 24'd0, 8'h00, 1'b0);
    queue_beam(24'd5001, 8'h80, 24'd0, 8'h00, 1'b1);
    queue_beam(24'd5000, 8'h7F, 24'd0, 8'h00, 1'b0);

    // distance mode with start above stop, and failing gates
    apply_cfg(make_cfg(MODE_DIST, 8'h40, 8'hC0, 24'd1000, 24'd10, GAIN_RST));
    queue_beam(24'd0,    8'h40, 24'd999,  8'hC0, 1'b0);
    queue_beam(24'd2000, 8'hFF, 24'd1000, 8'hFF, 1'b0);
    queue_beam(24'd0,    8'h40, 24'd5,    8'hBF, 1'b0);
    queue_beam(24'd0,    8'h3F, 24'd5,    8'hC0, 1'b1);

    // unused mode code over the full depth range
    apply_cfg(make_cfg(2'd3, 8'h00, 8'h00, 24'd0, 24'hFFFFFF, 16'h0000));
    queue_beam(24'h000000, 8'h00, 24'hFFFFFF, 8'h00, 1'b0);
    queue_beam(24'hFFFFFF, 8'hFF, 24'h000000, 8'hFF, 1'b1);
    queue_beam(24'd123,    8'h55, 24'd123,    8'hAA, 1'b0);
    queue_beam(24'd0,      8'hAA, 24'h800000, 8'h55, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      c = rand_cfg();
      apply_cfg(c);
      calm = (p == PHASES - 1);
      for (int i = 0; i < PHASE_LEN; i++) queue_random_beam(c);
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_pixels.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/cgpm_pkg.sv
rtl/cgpm_front.sv
rtl/cgpm_div_stage.sv
rtl/cscan_gate_pixel_mapper.sv
bench/tb.sv
